// ----- rtl/core/srsa_pkg.sv -----
// Shared types and constants for the sparse row store accumulate block.
package srsa_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Operation codes (the unused code behaves as a read)
    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_ACC  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Field widths fixed by the interface
    localparam int VAL_W      = 32;
    localparam int ROW_W      = 8;
    localparam int NROWS_W    = 9;
    localparam int NCOLS_W    = 17;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // Register map (word index taken from paddr[2])
    localparam logic REG_ROW_LIMIT = 1'b0;
    localparam logic REG_COL_LIMIT = 1'b1;

    localparam logic [NROWS_W-1:0] ROW_LIMIT_RST = 9'd256;
    localparam logic [NCOLS_W-1:0] COL_LIMIT_RST = 17'd65536;

    // Q16.16 saturation limits
    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

endpackage

// ----- rtl/core/sparse_row_store_accumulate.sv -----
// Sparse matrix row store: per-row column/value lists with set, accumulate and read.
// Each accepted item has its row word read in ST_IDLE; the result beat is registered as
// ST_EXEC completes, which waits while a held result beat is stalled, and no new item is
// taken until then. Each row lives in one wide memory word, written back by ST_EXEC.
// Reset: synchronous, active low; a clearing pass over all rows zeroes each fill count
// while the input stalls. The row limit resets to 256, the column limit to 65536.
module sparse_row_store_accumulate #(
    parameter int MAX_ROWS        = 256,
    parameter int ENTRIES_PER_ROW = 16,
    parameter int COL_BITS        = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [srsa_pkg::ROW_W-1:0]    i_row_index,
    input  logic [COL_BITS-1:0]           i_col_index,
    input  logic signed [srsa_pkg::VAL_W-1:0] i_value_in,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [srsa_pkg::VAL_W-1:0] o_read_value,
    output logic                          o_found,
    output logic [1:0]                    o_status,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srsa_pkg::APB_AW-1:0]   paddr,
    input  logic [srsa_pkg::APB_DW-1:0]   pwdata,
    output logic [srsa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import srsa_pkg::*;

    localparam int RAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int FILL_W = $clog2(ENTRIES_PER_ROW + 1);
    localparam int SEL_W  = (ENTRIES_PER_ROW > 1) ? $clog2(ENTRIES_PER_ROW) : 1;
    localparam int SLOT_W = COL_BITS + VAL_W;
    localparam int FILL_LSB = ENTRIES_PER_ROW * SLOT_W;
    localparam int WORD_W = FILL_LSB + FILL_W;
    localparam logic [RAW-1:0]    LAST_ROW = RAW'(MAX_ROWS - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(ENTRIES_PER_ROW);

    // Configuration registers
    logic [NROWS_W-1:0] r_row_limit;
    logic [NCOLS_W-1:0] r_col_limit;

    // Control state
    t_state           r_state, n_state;
    logic [RAW-1:0]   r_clr_addr;

    // Latched item
    logic [1:0]              r_op;
    logic [ROW_W-1:0]        r_row;
    logic [COL_BITS-1:0]     r_col;
    logic [VAL_W-1:0]        r_val;

    // Row memory and its registered read data
    logic [WORD_W-1:0] mem [MAX_ROWS];
    logic [WORD_W-1:0] r_rd_word;

    // Result register
    logic                 r_out_valid;
    logic [VAL_W-1:0]     r_read_value;
    logic                 r_found;
    logic [1:0]           r_status;

    logic in_accept;
    logic exec_fire;
    logic cfg_write;

    logic              mem_re;
    logic              mem_we;
    logic [RAW-1:0]    mem_raddr;
    logic [RAW-1:0]    mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // Row modify results
    logic [FILL_W-1:0] rd_fill;
    logic [ENTRIES_PER_ROW-1:0] hit_vec;
    logic              present;
    logic [SEL_W-1:0]  sel;
    logic [VAL_W-1:0]  sel_value;
    logic              out_of_range;
    logic              row_full;
    logic              is_write_op;
    logic              do_write;
    logic [VAL_W:0]    sum;
    logic [VAL_W-1:0]  acc_value;
    logic [VAL_W-1:0]  new_value;
    logic [WORD_W-1:0] n_word;
    logic [VAL_W-1:0]  n_read_value;
    logic              n_found;
    logic [1:0]        n_status;
    logic [31:0]       row_ext;
    logic [31:0]       in_row_ext;

    assign in_accept = i_in_valid && !o_in_stall;
    assign exec_fire = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);
    assign cfg_write = psel && penable && pwrite && pready;
    assign row_ext    = 32'(r_row);
    assign in_row_ext = 32'(i_row_index);

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_limit <= ROW_LIMIT_RST;
            r_col_limit <= COL_LIMIT_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_ROW_LIMIT: r_row_limit <= pwdata[NROWS_W-1:0];
                REG_COL_LIMIT: r_col_limit <= pwdata[NCOLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROW_LIMIT: prdata = APB_DW'(r_row_limit);
            REG_COL_LIMIT: prdata = APB_DW'(r_col_limit);
            default:       prdata = '0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr_addr == LAST_ROW) n_state = ST_IDLE;
            ST_IDLE:  if (in_accept) n_state = ST_EXEC;
            ST_EXEC:  if (exec_fire) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // State outputs: stall and memory control
    always_comb begin
        o_in_stall = 1'b1;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_raddr  = in_row_ext[RAW-1:0];
        mem_waddr  = row_ext[RAW-1:0];
        mem_wdata  = n_word;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                mem_re     = i_in_valid;
            end
            ST_EXEC: begin
                mem_we = exec_fire && do_write;
            end
            default: ;
        endcase
    end

    // State, clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + RAW'(1);
        end
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= i_opcode;
            r_row <= i_row_index;
            r_col <= i_col_index;
            r_val <= i_value_in;
        end
    end

    // Row memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_word <= mem[mem_raddr];
    end

    // Column search over the stored slots of the row
    always_comb begin
        rd_fill = r_rd_word[FILL_LSB +: FILL_W];
        for (int k = 0; k < ENTRIES_PER_ROW; k++) begin
            hit_vec[k] = (FILL_W'(k) < rd_fill) &&
                         (r_rd_word[k*SLOT_W +: COL_BITS] == r_col);
        end
        present = |hit_vec;
        // first matching slot wins
        sel = '0;
        for (int k = ENTRIES_PER_ROW - 1; k >= 0; k--) begin
            if (hit_vec[k]) sel = SEL_W'(k);
        end
        sel_value = r_rd_word[32'(sel)*SLOT_W + COL_BITS +: VAL_W];
    end

    // Range check, saturating add, row update
    always_comb begin
        out_of_range = ({1'b0, r_row} >= r_row_limit) || (row_ext >= 32'(MAX_ROWS)) ||
                       (33'(r_col) >= 33'(r_col_limit));
        row_full = (rd_fill >= FULL_FILL);
        case (r_op)
            OP_SET, OP_ACC: is_write_op = 1'b1;
            default:        is_write_op = 1'b0;
        endcase

        sum = {sel_value[VAL_W-1], sel_value} + {r_val[VAL_W-1], r_val};
        if (sum[VAL_W] != sum[VAL_W-1]) acc_value = sum[VAL_W] ? VAL_MIN : VAL_MAX;
        else                            acc_value = sum[VAL_W-1:0];

        new_value = (present && (r_op == OP_ACC)) ? acc_value : r_val;

        n_word       = r_rd_word;
        do_write     = 1'b0;
        n_read_value = '0;
        n_found      = 1'b0;
        n_status     = STAT_OK;

        if (out_of_range) begin
            n_status = STAT_RANGE;
        end else if (!is_write_op) begin
            if (present) begin
                n_read_value = sel_value;
                n_found      = 1'b1;
            end
        end else if (present) begin
            do_write     = 1'b1;
            n_found      = 1'b1;
            n_read_value = new_value;
            for (int k = 0; k < ENTRIES_PER_ROW; k++) begin
                if (SEL_W'(k) == sel) n_word[k*SLOT_W + COL_BITS +: VAL_W] = new_value;
            end
        end else if (row_full) begin
            n_status = STAT_FULL;
        end else begin
            // append at the first free slot
            do_write     = 1'b1;
            n_read_value = r_val;
            for (int k = 0; k < ENTRIES_PER_ROW; k++) begin
                if (FILL_W'(k) == rd_fill) begin
                    n_word[k*SLOT_W +: COL_BITS]            = r_col;
                    n_word[k*SLOT_W + COL_BITS +: VAL_W]    = r_val;
                end
            end
            n_word[FILL_LSB +: FILL_W] = rd_fill + FILL_W'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_read_value <= n_read_value;
            r_found      <= n_found;
            r_status     <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_found      = r_found;
    assign o_status     = r_status;

`ifndef ASSERT_OFF
    // an accepted beat always moves to the write-back cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_EXEC))
        else $error("accepted beat did not enter write-back");

    // memory writes only come from clearing or a completing item
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_CLEAR) || exec_fire)
        else $error("stray row memory write");

    // written fill never exceeds the row capacity
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (mem_wdata[FILL_LSB +: FILL_W] <= FULL_FILL))
        else $error("row fill above capacity");

    // a completed item always presents a result beat
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |=> o_out_valid)
        else $error("result beat lost");

    // refused items carry zero value and no hit
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STAT_OK)) |-> (o_read_value == '0) && !o_found)
        else $error("refused item with payload");
`endif

endmodule
